[hdl/assert_macros.svh]
// Assertion macros for the port-level checker, wfg_checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge -> b holds at the same edge
`define ASSERT_SAME(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a holds at an edge -> b holds at the next edge
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[hdl/wfg_pkg.sv]
// Package for the wait-for graph deadlock check: types, codes, defaults.
// No dependencies; used by every module of the block but wfg_peel.
`timescale 1ns / 1ps

package wfg_pkg;

    localparam int THREADS_DEF = 8;
    localparam int LOCKS_DEF   = 8;
    localparam int IDX_W       = 3;
    localparam int OP_W        = 2;
    localparam int DATA_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_PEEL
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
        logic load_out;
    } ctrl_t;

endpackage

[hdl/wfg_peel.sv]
// One peel step of the cycle search over the wait-for graph.
// Depends on nothing but its parameters; used by the top level.
`timescale 1ns / 1ps

module wfg_peel #(
    parameter int THREADS = 8,
    parameter int LOCKS   = 8
) (
    input  logic [THREADS-1:0][LOCKS-1:0] waits_for,
    input  logic [LOCKS-1:0][THREADS-1:0] held_by,
    input  logic [THREADS-1:0]            alive_t,
    input  logic [LOCKS-1:0]              alive_l,
    output logic [THREADS-1:0]            alive_t_nx,
    output logic [LOCKS-1:0]              alive_l_nx
);

    // a node stays alive only while it has an edge to a live node
    always_comb
    begin
        for (int i = 0; i < THREADS; i++)
        begin
            alive_t_nx[i] = alive_t[i] & (|(waits_for[i] & alive_l));
        end
        for (int j = 0; j < LOCKS; j++)
        begin
            alive_l_nx[j] = alive_l[j] & (|(held_by[j] & alive_t));
        end
    end

endmodule

[hdl/wfg_ctrl.sv]
// Sequencer of the deadlock check: accepts a transfer, runs the peel loop.
// Depends on wfg_pkg.
`timescale 1ns / 1ps

module wfg_ctrl
    import wfg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  logic  out_free,
    input  logic  is_request,
    input  logic  converged,
    output logic  s_tready,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && out_free && is_request)
                begin
                    state_next = ST_PEEL;
                end
            end
            ST_PEEL:
            begin
                if (converged)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        ctrl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready      = out_free;
                ctrl.accept   = s_tvalid && out_free;
                ctrl.load_out = s_tvalid && out_free && !is_request;
            end
            ST_PEEL:
            begin
                ctrl.step     = 1'b1;
                ctrl.finish   = converged;
                ctrl.load_out = converged;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[hdl/wait_for_graph_deadlock_check.sv]
// Top level of the wait-for graph deadlock check: graph matrices, peel loop.
// Depends on wfg_pkg, wfg_peel and wfg_ctrl.
//
//  port group  dir  fields (lowest bit first)
//  s_*         in   tuser: req_type; tdata: thread_idx, lock_idx
//  m_*         out  tdata: status
//
// Acquire, release and out-of-range or unknown operations load their status
// on acceptance; it is valid in the next cycle. A request runs peel steps
// until stable; the shared peel unit removes all dead-end nodes once per cycle.
// Reset clears both matrices at once; no sweep is needed.
// A result waiting on m_tready holds s_tready low until it is taken.
`timescale 1ns / 1ps

module wait_for_graph_deadlock_check
    import wfg_pkg::*;
#(
    parameter int THREADS = THREADS_DEF,
    parameter int LOCKS   = LOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,  // thread_idx, lock_idx
    input  logic [OP_W-1:0]   s_tuser,  // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata   // status
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;

    logic [THREADS-1:0][LOCKS-1:0] waits_reg, waits_next;
    logic [LOCKS-1:0][THREADS-1:0] held_reg, held_next;
    logic [THREADS-1:0]            alive_t_reg, alive_t_next, alive_t_nx;
    logic [LOCKS-1:0]              alive_l_reg, alive_l_next, alive_l_nx;
    logic [TW-1:0]                 t_reg, t_next, t_in;
    logic [LW-1:0]                 l_reg, l_next, l_in;
    logic                          m_valid_reg, m_valid_next;
    logic                          status_reg, status_next;
    logic                          in_range, is_request, converged, cycle_found;
    logic                          out_free;
    ctrl_t                         ctrl;

    assign in_range   = (32'(s_tdata[IDX_W-1:0]) < THREADS)
                     && (32'(s_tdata[2*IDX_W-1:IDX_W]) < LOCKS);
    assign is_request = in_range && (s_tuser == OP_REQUEST);
    assign t_in       = TW'(s_tdata[IDX_W-1:0]);
    assign l_in       = LW'(s_tdata[2*IDX_W-1:IDX_W]);
    assign out_free   = !m_valid_reg || m_tready;

    assign converged   = (alive_t_nx == alive_t_reg) && (alive_l_nx == alive_l_reg);
    assign cycle_found = (|alive_t_reg) || (|alive_l_reg);

    wfg_peel #(
        .THREADS (THREADS),
        .LOCKS   (LOCKS)
    ) u_peel (
        .waits_for  (waits_reg),
        .held_by    (held_reg),
        .alive_t    (alive_t_reg),
        .alive_l    (alive_l_reg),
        .alive_t_nx (alive_t_nx),
        .alive_l_nx (alive_l_nx)
    );

    wfg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .out_free   (out_free),
        .is_request (is_request),
        .converged  (converged),
        .s_tready   (s_tready),
        .ctrl       (ctrl)
    );

    always_comb
    begin
        waits_next   = waits_reg;
        held_next    = held_reg;
        alive_t_next = alive_t_reg;
        alive_l_next = alive_l_reg;
        t_next       = t_reg;
        l_next       = l_reg;
        if (ctrl.accept)
        begin
            t_next = t_in;
            l_next = l_in;
            if (in_range)
            begin
                case (s_tuser)
                    OP_REQUEST:
                    begin
                        waits_next[t_in][l_in] = 1'b1;
                        alive_t_next           = '1;
                        alive_l_next           = '1;
                    end
                    OP_ACQUIRE:
                    begin
                        waits_next[t_in][l_in] = 1'b0;
                        held_next[l_in][t_in]  = 1'b1;
                    end
                    OP_RELEASE:
                    begin
                        held_next[l_in][t_in] = 1'b0;
                    end
                    default:
                    begin
                        held_next = held_reg;
                    end
                endcase
            end
        end
        if (ctrl.step)
        begin
            alive_t_next = alive_t_nx;
            alive_l_next = alive_l_nx;
        end
        // refused request: drop its wait edge again
        if (ctrl.finish && cycle_found)
        begin
            waits_next[t_reg][l_reg] = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        if (ctrl.load_out)
        begin
            m_valid_next = 1'b1;
            status_next  = (ctrl.finish && cycle_found) ? STATUS_REFUSED : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waits_reg   <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            waits_reg   <= waits_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alive_t_reg <= alive_t_next;
        alive_l_reg <= alive_l_next;
        t_reg       <= t_next;
        l_reg       <= l_next;
        status_reg  <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(DATA_W-1){1'b0}}, status_reg};

endmodule

[hdl/wfg_checker.sv]
// Port-level checker for the wait-for graph deadlock check, with its bind.
// Depends on wfg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wfg_checker
    import wfg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [OP_W-1:0]   s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;

    `ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata))
    `ASSERT_SAME(a_no_take_on_stall, out_stall, !s_tready)
    `ASSERT_NEXT(a_fast_ops_done, in_xfer && (s_tuser != OP_REQUEST),
                 m_tvalid && (m_tdata == '0))
    `ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[DATA_W-1:1] == '0)

endmodule

bind wait_for_graph_deadlock_check wfg_checker u_wfg_checker (.*);

[tb/wfg_status_checker.sv]
// Checker for the wait-for graph deadlock check: tracks the graph state,
// predicts the status of every input transfer and compares the results.
// Depends on wfg_pkg; instantiated by tb_wait_for_graph_deadlock_check.
`timescale 1ns / 1ps

module wfg_status_checker
    import wfg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,  // thread_idx, lock_idx
    input  logic [OP_W-1:0]   s_tuser,  // req_type
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,  // status
    output int                fail_count,
    output int                pending
);

    localparam int N_THR = THREADS_DEF;
    localparam int N_LCK = LOCKS_DEF;

    logic [N_LCK-1:0] thread_waits [N_THR];  // thread -> lock edges
    logic [N_THR-1:0] lock_holders [N_LCK];  // lock -> thread edges
    logic             status_queue [$];

    // peel dead-end nodes until stable; anything left means a cycle
    function automatic bit wait_graph_cyclic();
        logic [N_THR-1:0] live_t;
        logic [N_LCK-1:0] live_l;
        bit               changed;
        live_t  = '1;
        live_l  = '1;
        changed = 1'b1;
        while (changed)
        begin
            changed = 1'b0;
            for (int i = 0; i < N_THR; i++)
            begin
                if (live_t[i] && (thread_waits[i] & live_l) == '0)
                begin
                    live_t[i] = 1'b0;
                    changed   = 1'b1;
                end
            end
            for (int i = 0; i < N_LCK; i++)
            begin
                if (live_l[i] && (lock_holders[i] & live_t) == '0)
                begin
                    live_l[i] = 1'b0;
                    changed   = 1'b1;
                end
            end
        end
        return (live_t != '0) || (live_l != '0);
    endfunction

    function automatic logic lock_step_status(logic [OP_W-1:0] op,
                                              logic [IDX_W-1:0] thr,
                                              logic [IDX_W-1:0] lck);
        logic status;
        status = STATUS_OK;
        if (thr < N_THR && lck < N_LCK)
        begin
            case (op)
                OP_REQUEST:
                begin
                    thread_waits[thr][lck] = 1'b1;
                    if (wait_graph_cyclic())
                    begin
                        thread_waits[thr][lck] = 1'b0;
                        status = STATUS_REFUSED;
                    end
                end
                OP_ACQUIRE:
                begin
                    thread_waits[thr][lck] = 1'b0;
                    lock_holders[lck][thr] = 1'b1;
                end
                OP_RELEASE:
                begin
                    lock_holders[lck][thr] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        return status;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_THR; i++)
                thread_waits[i] = '0;
            for (int i = 0; i < N_LCK; i++)
                lock_holders[i] = '0;
            status_queue.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                status_queue.push_back(lock_step_status(s_tuser,
                    s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W]));
            if (m_tvalid && m_tready)
            begin
                if (status_queue.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual status %0d",
                             $time, m_tdata[0]);
                    fail_count++;
                end
                else if (status_queue[0] !== m_tdata[0])
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, status_queue[0], m_tdata[0]);
                    fail_count++;
                    void'(status_queue.pop_front());
                end
                else
                    void'(status_queue.pop_front());
            end
            pending = status_queue.size();
        end
    end

endmodule

[tb/tb_wait_for_graph_deadlock_check.sv]
// Top of the testbench for the wait-for graph deadlock check: clock, reset,
// directed and random lock traffic, stalls, watchdog and verdict.
// Depends on wfg_pkg, wait_for_graph_deadlock_check and wfg_status_checker.
`timescale 1ns / 1ps

module tb_wait_for_graph_deadlock_check;
    import wfg_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int N_IDX       = THREADS_DEF;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]   s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    int                fail_count;
    int                pending;

    int   src_idle  = 0;
    int   snk_stall = 0;
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    // rough picture of the traffic sent so far, used to shape random items
    bit [N_IDX-1:0] asked [N_IDX];
    bit [N_IDX-1:0] owns  [N_IDX];

    wait_for_graph_deadlock_check DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wfg_status_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side; a kick starts a long hold-off
    always @(negedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= snk_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_step(logic [OP_W-1:0] op, logic [IDX_W-1:0] thr,
                             logic [IDX_W-1:0] lck);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DATA_W - 2*IDX_W){1'b0}}, lck, thr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_idx();
        if ($urandom_range(0, 3) == 0)
            return IDX_W'($urandom_range(0, N_IDX - 1));
        return IDX_W'($urandom_range(0, 3));
    endfunction

    function automatic bit lock_free(logic [IDX_W-1:0] lck);
        for (int i = 0; i < N_IDX; i++)
            if (owns[i][lck])
                return 1'b0;
        return 1'b1;
    endfunction

    // mostly request/acquire/release traffic on a few threads and locks
    task automatic send_lock_traffic();
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] thr;
        logic [IDX_W-1:0] lck;
        int               sel;
        bit               found;
        sel   = $urandom_range(0, 99);
        found = 1'b0;
        thr   = pick_idx();
        lck   = pick_idx();
        op    = OP_REQUEST;
        if (sel < 10)
        begin
            op  = OP_W'($urandom_range(int'(OP_REQUEST), int'(OP_UNKNOWN)));
            thr = IDX_W'($urandom_range(0, N_IDX - 1));
            lck = IDX_W'($urandom_range(0, N_IDX - 1));
        end
        else if (sel < 72)
        begin
            for (int k = 0; k < 8 && !found; k++)
            begin
                thr = pick_idx();
                lck = pick_idx();
                if (sel < 50 && asked[thr][lck] && lock_free(lck))
                    found = 1'b1;
                if (sel >= 50 && owns[thr][lck])
                    found = 1'b1;
            end
            if (found)
                op = (sel < 50) ? OP_ACQUIRE : OP_RELEASE;
            else if (sel >= 50 && $urandom_range(0, 3) == 0)
                op = OP_RELEASE;
        end
        case (op)
            OP_REQUEST: asked[thr][lck] = 1'b1;
            OP_ACQUIRE:
            begin
                asked[thr][lck] = 1'b0;
                owns[thr][lck]  = 1'b1;
            end
            OP_RELEASE: owns[thr][lck] = 1'b0;
            default:
            begin
            end
        endcase
        send_step(op, thr, lck);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        src_idle  = idle_pct;
        snk_stall = stall_pct;
        repeat (count)
            send_lock_traffic();
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < N_IDX; i++)
        begin
            asked[i] = '0;
            owns[i]  = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, unknown operation, unmatched release
        send_step(OP_REQUEST, 3'd0, 3'd0);
        send_step(OP_ACQUIRE, 3'd0, 3'd0);
        send_step(OP_REQUEST, 3'd7, 3'd7);
        send_step(OP_ACQUIRE, 3'd7, 3'd7);
        send_step(OP_RELEASE, 3'd7, 3'd7);
        send_step(OP_UNKNOWN, 3'd7, 3'd7);
        send_step(OP_UNKNOWN, 3'd0, 3'd0);
        send_step(OP_RELEASE, 3'd3, 3'd5);
        // two threads crossing on two locks
        send_step(OP_ACQUIRE, 3'd1, 3'd1);
        send_step(OP_ACQUIRE, 3'd2, 3'd2);
        send_step(OP_REQUEST, 3'd1, 3'd2);
        send_step(OP_REQUEST, 3'd2, 3'd1);
        // acquire of a held lock without a check; it closes no cycle, later requests pass
        send_step(OP_ACQUIRE, 3'd2, 3'd1);
        send_step(OP_REQUEST, 3'd5, 3'd6);
        send_step(OP_REQUEST, 3'd1, 3'd2);
        // second holder on an already held lock
        send_step(OP_ACQUIRE, 3'd3, 3'd0);
        send_step(OP_RELEASE, 3'd2, 3'd1);
        send_step(OP_RELEASE, 3'd1, 3'd1);
        send_step(OP_RELEASE, 3'd2, 3'd2);
        send_step(OP_RELEASE, 3'd0, 3'd0);
        send_step(OP_RELEASE, 3'd3, 3'd0);
        send_step(OP_REQUEST, 3'd4, 3'd3);
        drain();

        run_phase(0, 0, 120);
        run_phase(49, 0, 120);
        run_phase(0, 49, 120);
        run_phase(16, 16, 120);

        // long result hold-off while items keep coming
        @(posedge clk);
        hold_kick <= ~hold_kick;
        run_phase(0, 0, 60);

        run_phase(16, 16, 60);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
